/* rtl/slbr_pkg.sv */
// Shared types and constants for the scanline line-buffer rasterizer.
package slbr_pkg;

  localparam int COLOR_W = 16;
  localparam int COORD_W = 12;
  localparam int COL_W   = 10;
  localparam int CWID_W  = 11;
  localparam int ROW_W   = 10;
  localparam int RAD_W   = 10;
  localparam int QUAD_W  = 3;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int ROOT_W  = 10;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int EXT_W   = 14;

  localparam logic [CWID_W-1:0] CLIP_WIDTH_RST = 11'd800;

  localparam logic [CIDX_W-1:0] CFG_CLIP_LEFT  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CLIP_WIDTH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TARGET_ROW = 2'd2;

  localparam logic [QUAD_W-1:0] QUAD_TL   = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_TR   = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_BL   = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_BR   = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_FULL = 3'd4;

  typedef enum logic [1:0] {
    OP_RECT   = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

endpackage

/* rtl/scanline_line_buffer_rasterizer.sv */
// Top level: command sequencer around the line buffer memory and square-root unit.
//
// Usage: raise start with a command on the operation and field ports; the
// command is taken at a clock edge where start is high and busy is low.
// Drawing commands (rectangle, pixel, circle row) return nothing; a read
// returns one beat on pixel_color, marked by pixel_valid for one cycle.
// The receiver cannot stall; pixel_valid is a single-cycle strobe.
// Configuration registers (0 clip_left, 1 clip_width, 2 target_row) are
// written through wr_en / wr_index / wr_data; the user must write them
// only while busy is low, which the block does not enforce. Steps until busy falls:
//   rectangle and pixel write: a setup state, then the span fill.
//   circle row: a squaring state, a state to start the root unit, the root
//   search (ROOT_W bits at one per cycle, then the done pulse), a setup state,
//   then the span fill; if the row is not drawn it ends after squaring.
//   read: a state for the buffer memory read latency, then one for the output
//   register; pixel_valid rises at the edge where busy falls.
// Span fills write the memory at one pixel per cycle; that write port sets
// the fill rate. After reset the block runs a clearing pass that writes zero
// to every pixel; busy stays high during it while configuration writes are
// still taken.
module scanline_line_buffer_rasterizer #(
  parameter int LINE_WIDTH = 800
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [slbr_pkg::COORD_W-1:0]  x,
  input  logic [slbr_pkg::COORD_W-1:0]  y,
  input  logic [slbr_pkg::COORD_W-1:0]  span_width,
  input  logic [slbr_pkg::COORD_W-1:0]  span_height,
  input  logic [slbr_pkg::RAD_W-1:0]    radius,
  input  logic [slbr_pkg::QUAD_W-1:0]   quadrant,
  input  logic [slbr_pkg::COLOR_W-1:0]  color,
  input  logic                          wr_en,
  input  logic [slbr_pkg::CIDX_W-1:0]   wr_index,
  input  logic [slbr_pkg::CFG_W-1:0]    wr_data,
  output logic                          pixel_valid,
  output logic [slbr_pkg::COLOR_W-1:0]  pixel_color
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int EW = slbr_pkg::EXT_W;
  localparam int CW = slbr_pkg::COORD_W;
  localparam int RW = slbr_pkg::RAD_W;
  localparam int SW = slbr_pkg::SQ_W;
  localparam logic signed [EW-1:0] LW_S = EW'(LINE_WIDTH);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CIRC,
    S_SQSTART,
    S_SQRT,
    S_SETUP,
    S_FILL,
    S_RDADDR,
    S_RDDATA
  } state_t;

  state_t state;

  logic [AW:0]                        ptr;
  logic [AW:0]                        ptr_inc;
  logic [AW:0]                        span_end;
  slbr_pkg::op_t                      op_r;
  logic [CW-1:0]                      x_r;
  logic [CW-1:0]                      y_r;
  logic [CW-1:0]                      w_r;
  logic [CW-1:0]                      h_r;
  logic [RW-1:0]                      rad_r;
  logic [slbr_pkg::QUAD_W-1:0]        quad_r;
  logic [slbr_pkg::COLOR_W-1:0]       color_r;
  logic [slbr_pkg::COL_W-1:0]         clip_left;
  logic [slbr_pkg::CWID_W-1:0]        clip_width;
  logic [slbr_pkg::ROW_W-1:0]         target_row;
  logic [SW-1:0]                      rr;
  logic [SW-1:0]                      dd;

  logic signed [EW-1:0] xs, ys, ws, hs, row_s, rad_s, dx_s, dy, dabs;
  logic signed [EW-1:0] win_lo, win_hi;
  logic signed [EW-1:0] lo_raw, hi_raw, lo, hi;
  logic                 span_en;
  logic                 circ_ok;
  logic                 x_in_buf;

  logic                               sq_start;
  logic                               sq_done;
  logic [slbr_pkg::ROOT_W-1:0]        sq_root;

  logic                               mem_we;
  logic [slbr_pkg::COLOR_W-1:0]       mem_wdata;
  logic [slbr_pkg::COLOR_W-1:0]       mem_rdata;

  assign busy = (state != S_IDLE);

  assign xs    = {{(EW-CW){x_r[CW-1]}}, x_r};
  assign ys    = {{(EW-CW){y_r[CW-1]}}, y_r};
  assign ws    = {{(EW-CW){w_r[CW-1]}}, w_r};
  assign hs    = {{(EW-CW){h_r[CW-1]}}, h_r};
  assign row_s = {{(EW-slbr_pkg::ROW_W){1'b0}}, target_row};
  assign rad_s = {{(EW-RW){1'b0}}, rad_r};
  assign dx_s  = {{(EW-slbr_pkg::ROOT_W){1'b0}}, sq_root};
  assign dy    = row_s - ys;
  assign dabs  = dy[EW-1] ? -dy : dy;

  assign win_lo = {{(EW-slbr_pkg::COL_W){1'b0}}, clip_left};
  assign win_hi = {{(EW-slbr_pkg::COL_W){1'b0}}, clip_left}
                + {{(EW-slbr_pkg::CWID_W){1'b0}}, clip_width};

  assign x_in_buf = (xs >= 0) && (xs < LW_S);
  assign ptr_inc  = ptr + 1'b1;

  always_comb begin
    circ_ok = 1'b0;
    case (quad_r) inside
      slbr_pkg::QUAD_TL, slbr_pkg::QUAD_TR: circ_ok = (dy <= 0);
      slbr_pkg::QUAD_BL, slbr_pkg::QUAD_BR: circ_ok = (dy >= 0);
      slbr_pkg::QUAD_FULL:                  circ_ok = (rad_r != '0);
      default:                              circ_ok = 1'b0;
    endcase
    circ_ok = circ_ok && (dy >= -rad_s) && (dy <= rad_s);
  end

  always_comb begin
    span_en = 1'b0;
    lo_raw  = xs;
    hi_raw  = xs + EW'(1);
    case (op_r)
      slbr_pkg::OP_RECT: begin
        span_en = (ws > 0) && (hs > 0) && (ys <= row_s) && (ys + hs > row_s);
        hi_raw  = xs + ws;
      end
      slbr_pkg::OP_PIXEL: begin
        span_en = (ys == row_s);
      end
      slbr_pkg::OP_CIRCLE: begin
        span_en = 1'b1;
        case (quad_r) inside
          slbr_pkg::QUAD_TL, slbr_pkg::QUAD_BL: begin
            lo_raw = xs - dx_s;
            hi_raw = xs + EW'(1);
          end
          slbr_pkg::QUAD_TR, slbr_pkg::QUAD_BR: begin
            lo_raw = xs;
            hi_raw = xs + dx_s + EW'(1);
          end
          default: begin
            lo_raw = xs - dx_s;
            hi_raw = xs + dx_s + EW'(1);
          end
        endcase
      end
      default: span_en = 1'b0;
    endcase
    lo = (lo_raw > win_lo) ? lo_raw : win_lo;
    hi = (hi_raw < win_hi) ? hi_raw : win_hi;
    if (hi > LW_S) begin
      hi = LW_S;
    end
  end

  assign sq_start  = (state == S_SQSTART);
  assign mem_we    = (state == S_CLEAR) || (state == S_FILL);
  assign mem_wdata = (state == S_FILL) ? color_r : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      ptr         <= '0;
      pixel_valid <= 1'b0;
      clip_left   <= '0;
      clip_width  <= slbr_pkg::CLIP_WIDTH_RST;
      target_row  <= '0;
    end else begin
      pixel_valid <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          slbr_pkg::CFG_CLIP_LEFT:  clip_left  <= wr_data[slbr_pkg::COL_W-1:0];
          slbr_pkg::CFG_CLIP_WIDTH: clip_width <= wr_data;
          slbr_pkg::CFG_TARGET_ROW: target_row <= wr_data[slbr_pkg::ROW_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr_inc;
          if (ptr == (AW+1)'(LINE_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= slbr_pkg::op_t'(operation);
            x_r     <= x;
            y_r     <= y;
            w_r     <= span_width;
            h_r     <= span_height;
            rad_r   <= radius;
            quad_r  <= quadrant;
            color_r <= color;
            unique case (slbr_pkg::op_t'(operation))
              slbr_pkg::OP_RECT, slbr_pkg::OP_PIXEL: state <= S_SETUP;
              slbr_pkg::OP_CIRCLE:                   state <= S_CIRC;
              slbr_pkg::OP_READ:                     state <= S_RDADDR;
              default:                               state <= S_IDLE;
            endcase
          end
        end
        S_CIRC: begin
          rr <= SW'(rad_r) * SW'(rad_r);
          dd <= SW'(dabs[RW-1:0]) * SW'(dabs[RW-1:0]);
          state <= circ_ok ? S_SQSTART : S_IDLE;
        end
        S_SQSTART: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          ptr      <= lo[AW:0];
          span_end <= hi[AW:0];
          state    <= (span_en && (lo < hi)) ? S_FILL : S_IDLE;
        end
        S_FILL: begin
          ptr <= ptr_inc;
          if (ptr_inc == span_end) begin
            state <= S_IDLE;
          end
        end
        S_RDADDR: begin
          state <= S_RDDATA;
        end
        S_RDDATA: begin
          pixel_valid <= 1'b1;
          pixel_color <= x_in_buf ? mem_rdata : '0;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  slbr_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (rr - dd),
    .done  (sq_done),
    .root  (sq_root)
  );

  slbr_line_mem #(
    .DEPTH (LINE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ptr[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (x_r[AW-1:0]),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/slbr_line_mem.sv */
// Line buffer memory: one write port, one read port with registered data.
module slbr_line_mem #(
  parameter int DEPTH = 800,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [slbr_pkg::COLOR_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [slbr_pkg::COLOR_W-1:0] rdata
);

  logic [slbr_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/slbr_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
module slbr_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [slbr_pkg::SQ_W-1:0]   value,
  output logic                        done,
  output logic [slbr_pkg::ROOT_W-1:0] root
);

  localparam int RW = slbr_pkg::ROOT_W;
  localparam int SW = slbr_pkg::SQ_W;
  localparam int IW = $clog2(RW);

  logic          run;
  logic [IW-1:0] idx;
  logic [SW-1:0] val;
  logic [RW-1:0] trial;
  logic [SW-1:0] trial_sq;

  assign trial    = root | (RW'(1) << idx);
  assign trial_sq = SW'(trial) * SW'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
      root <= '0;
      val  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        idx  <= IW'(RW - 1);
        root <= '0;
        val  <= value;
      end else if (run) begin
        if (trial_sq <= val) begin
          root <= trial;
        end
        if (idx == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

/* tb/scanline_line_buffer_rasterizer_tb.sv */
// Self-checking testbench for the scanline line-buffer rasterizer: directed and random commands.
module scanline_line_buffer_rasterizer_tb;

  localparam int LINE_WIDTH    = 800;
  localparam int SETTLE_CYCLES = 1100;
  localparam int IDLE_LIMIT    = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         start       = 1'b0;
  logic                         busy;
  logic [1:0]                   operation   = '0;
  logic [slbr_pkg::COORD_W-1:0] x           = '0;
  logic [slbr_pkg::COORD_W-1:0] y           = '0;
  logic [slbr_pkg::COORD_W-1:0] span_width  = '0;
  logic [slbr_pkg::COORD_W-1:0] span_height = '0;
  logic [slbr_pkg::RAD_W-1:0]   radius      = '0;
  logic [slbr_pkg::QUAD_W-1:0]  quadrant    = '0;
  logic [slbr_pkg::COLOR_W-1:0] color       = '0;
  logic                         wr_en       = 1'b0;
  logic [slbr_pkg::CIDX_W-1:0]  wr_index    = '0;
  logic [slbr_pkg::CFG_W-1:0]   wr_data     = '0;
  logic                         pixel_valid;
  logic [slbr_pkg::COLOR_W-1:0] pixel_color;

  logic [slbr_pkg::COLOR_W-1:0] line_pixels [LINE_WIDTH];
  logic [slbr_pkg::COLOR_W-1:0] expected_pixels [$];
  logic [slbr_pkg::COLOR_W-1:0] want_color;
  int clip_lo;
  int clip_cols;
  int row_sel;
  int errors  = 0;
  int n_cmds  = 0;
  int n_reads = 0;
  int n_cfg   = 0;
  bit no_idle = 1'b0;

  scanline_line_buffer_rasterizer #(.LINE_WIDTH(LINE_WIDTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .x(x), .y(y), .span_width(span_width), .span_height(span_height),
    .radius(radius), .quadrant(quadrant), .color(color),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .pixel_valid(pixel_valid), .pixel_color(pixel_color)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int sext(logic [slbr_pkg::COORD_W-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int floor_root(int v);
    int d;
    d = 0;
    for (int b = 512; b > 0; b >>= 1) begin
      if ((d + b) * (d + b) <= v) d += b;
    end
    return d;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic paint_span(int xs, int w, logic [slbr_pkg::COLOR_W-1:0] c);
    int lo;
    int hi;
    lo = xs;
    hi = xs + w;
    if (lo < clip_lo) lo = clip_lo;
    if (hi > clip_lo + clip_cols) hi = clip_lo + clip_cols;
    if (lo < 0) lo = 0;
    if (hi > LINE_WIDTH) hi = LINE_WIDTH;
    for (int i = lo; i < hi; i++) line_pixels[i] = c;
  endtask

  task automatic predict_command(slbr_pkg::op_t op,
                                 logic [slbr_pkg::COORD_W-1:0] xb,
                                 logic [slbr_pkg::COORD_W-1:0] yb,
                                 logic [slbr_pkg::COORD_W-1:0] wb,
                                 logic [slbr_pkg::COORD_W-1:0] hb,
                                 logic [slbr_pkg::RAD_W-1:0] rb,
                                 logic [slbr_pkg::QUAD_W-1:0] qb,
                                 logic [slbr_pkg::COLOR_W-1:0] c);
    int xv;
    int yv;
    int wv;
    int hv;
    int rv;
    int dy;
    int dx;
    int x1;
    int x2;
    xv = sext(xb);
    yv = sext(yb);
    wv = sext(wb);
    hv = sext(hb);
    rv = int'(rb);
    case (op)
      slbr_pkg::OP_RECT: begin
        if (wv > 0 && hv > 0 && yv <= row_sel && yv + hv > row_sel) begin
          x1 = (xv < clip_lo) ? clip_lo : xv;
          x2 = (xv + wv > clip_lo + clip_cols) ? clip_lo + clip_cols : xv + wv;
          if (x2 > x1) paint_span(x1, x2 - x1, c);
        end
      end
      slbr_pkg::OP_PIXEL: begin
        if (yv == row_sel && xv >= clip_lo && xv < clip_lo + clip_cols &&
            xv >= 0 && xv < LINE_WIDTH)
          line_pixels[xv] = c;
      end
      slbr_pkg::OP_CIRCLE: begin
        dy = row_sel - yv;
        if (qb <= slbr_pkg::QUAD_FULL && !(qb == slbr_pkg::QUAD_FULL && rv == 0) &&
            dy >= -rv && dy <= rv) begin
          dx = floor_root(rv * rv - dy * dy);
          if (dx > rv) dx = rv;
          case (qb)
            slbr_pkg::QUAD_TL: if (row_sel <= yv) paint_span(xv - dx, dx + 1, c);
            slbr_pkg::QUAD_TR: if (row_sel <= yv) paint_span(xv, dx + 1, c);
            slbr_pkg::QUAD_BL: if (row_sel >= yv) paint_span(xv - dx, dx + 1, c);
            slbr_pkg::QUAD_BR: if (row_sel >= yv) paint_span(xv, dx + 1, c);
            default: paint_span(xv - dx, 2 * dx + 1, c);
          endcase
        end
      end
      default: begin
        expected_pixels.push_back((xv >= 0 && xv < LINE_WIDTH) ? line_pixels[xv] : '0);
        n_reads++;
      end
    endcase
  endtask

  task automatic send_cmd(slbr_pkg::op_t op, int xv, int yv, int wv, int hv, int rv,
                          int qv, int cv);
    int gap;
    operation   <= op;
    x           <= xv[slbr_pkg::COORD_W-1:0];
    y           <= yv[slbr_pkg::COORD_W-1:0];
    span_width  <= wv[slbr_pkg::COORD_W-1:0];
    span_height <= hv[slbr_pkg::COORD_W-1:0];
    radius      <= rv[slbr_pkg::RAD_W-1:0];
    quadrant    <= qv[slbr_pkg::QUAD_W-1:0];
    color       <= cv[slbr_pkg::COLOR_W-1:0];
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    predict_command(op, xv[slbr_pkg::COORD_W-1:0], yv[slbr_pkg::COORD_W-1:0],
                    wv[slbr_pkg::COORD_W-1:0], hv[slbr_pkg::COORD_W-1:0],
                    rv[slbr_pkg::RAD_W-1:0], qv[slbr_pkg::QUAD_W-1:0],
                    cv[slbr_pkg::COLOR_W-1:0]);
    n_cmds++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_window(int cl, int cw, int row);
    wr_en    <= 1'b1;
    wr_index <= slbr_pkg::CFG_CLIP_LEFT;
    wr_data  <= cl[slbr_pkg::CFG_W-1:0];
    @(posedge clk);
    wr_index <= slbr_pkg::CFG_CLIP_WIDTH;
    wr_data  <= cw[slbr_pkg::CFG_W-1:0];
    @(posedge clk);
    wr_index <= slbr_pkg::CFG_TARGET_ROW;
    wr_data  <= row[slbr_pkg::CFG_W-1:0];
    @(posedge clk);
    wr_en    <= 1'b0;
    clip_lo   = cl & 1023;
    clip_cols = cw & 2047;
    row_sel   = row & 1023;
    n_cfg += 3;
  endtask

  // block idle and no reads outstanding, then room for a trailing draw
  task automatic wait_idle();
    int n;
    start <= 1'b0;
    n = 0;
    while ((expected_pixels.size() != 0 || busy) && n < IDLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && pixel_valid) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel beat with none expected, actual %h", $time, pixel_color);
      end else begin
        want_color = expected_pixels.pop_front();
        if (pixel_color !== want_color) begin
          errors++;
          $display("%0t: pixel_color expected %h actual %h", $time, want_color, pixel_color);
        end
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(slbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_READ, -2048, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_READ, 2047, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_rect_fill();
    send_cmd(slbr_pkg::OP_RECT, -5, 0, 20, 1, 0, 0, 16'hFFFF);
    send_cmd(slbr_pkg::OP_RECT, 30, 0, 0, 4, 0, 0, 16'h1111);
    send_cmd(slbr_pkg::OP_RECT, 30, 0, 10, -1, 0, 0, 16'h2222);
    send_cmd(slbr_pkg::OP_RECT, 30, 1, 10, 5, 0, 0, 16'h3333);
    send_cmd(slbr_pkg::OP_RECT, -2048, -2048, 2047, 2047, 0, 0, 16'h4444);
    send_cmd(slbr_pkg::OP_READ, 14, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_READ, 15, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_pixel_write();
    send_cmd(slbr_pkg::OP_PIXEL, LINE_WIDTH - 1, 0, 0, 0, 0, 0, 16'hA5A5);
    send_cmd(slbr_pkg::OP_PIXEL, LINE_WIDTH, 0, 0, 0, 0, 0, 16'h5A5A);
    send_cmd(slbr_pkg::OP_PIXEL, 10, 1, 0, 0, 0, 0, 16'h0F0F);
    send_cmd(slbr_pkg::OP_READ, LINE_WIDTH - 1, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_READ, LINE_WIDTH, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_circle_row();
    send_cmd(slbr_pkg::OP_CIRCLE, 200, 0, 0, 0, 0, slbr_pkg::QUAD_FULL, 16'h0001);
    send_cmd(slbr_pkg::OP_CIRCLE, 200, 0, 0, 0, 0, slbr_pkg::QUAD_BR, 16'h0002);
    send_cmd(slbr_pkg::OP_CIRCLE, 250, 0, 0, 0, 5, 7, 16'h0003);
    send_cmd(slbr_pkg::OP_CIRCLE, 300, -5, 0, 0, 10, slbr_pkg::QUAD_TL, 16'h0004);
    send_cmd(slbr_pkg::OP_CIRCLE, 300, -5, 0, 0, 10, slbr_pkg::QUAD_BL, 16'h0005);
    send_cmd(slbr_pkg::OP_CIRCLE, 500, 100, 0, 0, 10, slbr_pkg::QUAD_FULL, 16'h0006);
    send_cmd(slbr_pkg::OP_READ, 200, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_READ, 292, 0, 0, 0, 0, 0, 0);
    send_cmd(slbr_pkg::OP_CIRCLE, 400, 0, 0, 0, 1023, slbr_pkg::QUAD_FULL, 16'hC0DE);
  endtask

  task automatic test_clip_window();
    wait_idle();
    write_window(790, 1024, 0);
    send_cmd(slbr_pkg::OP_RECT, 780, 0, 100, 1, 0, 0, 16'hBEEF);
    send_cmd(slbr_pkg::OP_READ, 789, 0, 0, 0, 0, 0, 0);
    wait_idle();
    write_window(0, 0, 1023);
    send_cmd(slbr_pkg::OP_RECT, -10, 1000, 1000, 100, 0, 0, 16'hDEAD);
    send_cmd(slbr_pkg::OP_PIXEL, 5, 1023, 0, 0, 0, 0, 16'hDEAD);
    send_cmd(slbr_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic random_cmd();
    slbr_pkg::op_t op;
    int  xv;
    int  yv;
    int  wv;
    int  hv;
    int  rv;
    int  qv;
    int  p;
    p  = $urandom_range(0, 99);
    op = (p < 35) ? slbr_pkg::OP_READ : (p < 60) ? slbr_pkg::OP_RECT :
         (p < 75) ? slbr_pkg::OP_PIXEL : slbr_pkg::OP_CIRCLE;
    if ($urandom_range(0, 9) == 0) xv = $urandom_range(0, 4095);
    else xv = $urandom_range(0, LINE_WIDTH + 40) - 20;
    yv = $urandom_range(0, 4095);
    wv = $urandom_range(0, 4095);
    hv = $urandom_range(0, 4095);
    rv = $urandom_range(0, 1023);
    qv = $urandom_range(0, 7);
    case (op)
      slbr_pkg::OP_RECT: begin
        if ($urandom_range(0, 9) != 0) begin
          yv = row_sel - $urandom_range(0, 6);
          hv = $urandom_range(0, 8);
        end
        p = $urandom_range(0, 19);
        if (p < 17) wv = $urandom_range(0, 44) - 4;
        else if (p == 17) wv = $urandom_range(0, 1023);
      end
      slbr_pkg::OP_PIXEL: begin
        p = $urandom_range(0, 9);
        if (p < 7) yv = row_sel;
        else if (p < 9) yv = row_sel + $urandom_range(0, 4) - 2;
      end
      slbr_pkg::OP_CIRCLE: begin
        if ($urandom_range(0, 9) < 8) begin
          rv = $urandom_range(0, 24);
          yv = row_sel + $urandom_range(0, 2 * rv + 2) - rv - 1;
        end
        if ($urandom_range(0, 4) != 0) qv = $urandom_range(0, 4);
      end
      default: ;
    endcase
    send_cmd(op, xv, yv, wv, hv, rv, qv, $urandom_range(0, 65535));
  endtask

  task automatic test_random();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       write_window(0, 1024, 0);
        1:       write_window(1023, 1024, 1023);
        2:       write_window(0, 0, $urandom_range(0, 1023));
        3:       write_window(0, 800, $urandom_range(0, 1023));
        4:       write_window($urandom_range(0, 799), $urandom_range(0, 1024), 1023);
        default: write_window($urandom_range(0, 1023), $urandom_range(0, 1024),
                              $urandom_range(0, 1023));
      endcase
      no_idle = (ph == 3 || ph == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_results();
        random_cmd();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < LINE_WIDTH; i++) line_pixels[i] = '0;
    clip_lo   = 0;
    clip_cols = int'(slbr_pkg::CLIP_WIDTH_RST);
    row_sel   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_rect_fill();
    test_pixel_write();
    test_circle_row();
    test_clip_window();
    test_random();
    wait_idle();
    if (expected_pixels.size() != 0) begin
      errors += expected_pixels.size();
      $display("%0t: %0d pixel beats expected but never seen", $time, expected_pixels.size());
    end
    $display("Sent %0d commands, %0d of them reads compared against the shadow line,",
             n_cmds, n_reads);
    $display("across %0d register writes covering full, empty and off-buffer clip windows.",
             n_cfg);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
